// ----- design/spi_pkg.sv -----
// Shared types, widths and codes for the segment/plane intersection block.
`default_nettype none
package spi_pkg;

  localparam int CW     = 16;  // coordinate width, Q8.8
  localparam int PW     = 32;  // normal * coordinate product
  localparam int OW     = 24;  // plane offset width
  localparam int OSH    = 14;  // offset alignment to the product scale
  localparam int DW     = 39;  // signed plane distance
  localparam int NW     = 39;  // |s0|
  localparam int EW     = 40;  // |s0 - s1|
  localparam int RW     = 41;  // divider partial remainder
  localparam int FW     = 16;  // fraction bits of t
  localparam int NSTEP  = FW;  // one quotient bit per divider stage
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;
  localparam int AW     = 4;   // config address width

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_CROSS    = 2'd1,
    KIND_TOUCH    = 2'd2,
    KIND_ON_PLANE = 2'd3
  } kind_t;

  localparam logic [1:0] REG_NX  = 2'd0;
  localparam logic [1:0] REG_NY  = 2'd1;
  localparam logic [1:0] REG_NZ  = 2'd2;
  localparam logic [1:0] REG_OFF = 2'd3;

  localparam logic signed [CW-1:0] NZ_RESET = 16'sd16384;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_z;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] end_z;
  } seg_t;

  typedef struct packed {
    kind_t                cross_kind;
    logic signed [CW-1:0] hit_x;
    logic signed [CW-1:0] hit_y;
    logic signed [CW-1:0] hit_z;
  } hit_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [CW-1:0] nx;
    logic signed [CW-1:0] ny;
    logic signed [CW-1:0] nz;
    logic signed [OW-1:0] off;
  } plane_t;

  // Entry handed from the classifier to the divide/interpolate back end.
  typedef struct packed {
    kind_t         kind;
    vec_t          base;  // reported point, or segment start for a crossing
    vec_t          far;   // segment end, used only for a crossing
    logic [NW-1:0] num;
    logic [EW-1:0] den;
  } qent_t;

  typedef struct packed {
    logic  push;
    qent_t data;
  } qpush_t;

  typedef struct packed {
    logic  full;
    logic  empty;
    qent_t head;
  } qstat_t;

endpackage
`default_nettype wire

// ----- design/spi_if.sv -----
// Valid/ready channel interfaces for segment requests and hit results.
`default_nettype none
interface spi_in_if;
  import spi_pkg::*;
  logic valid;
  logic ready;
  seg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface spi_out_if;
  import spi_pkg::*;
  logic valid;
  logic ready;
  hit_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/spi_front.sv -----
// Front end: plane distances of both endpoints and crossing classification.
`default_nettype none
module spi_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  spi_in_if.sink               in_seg,
  input  wire spi_pkg::plane_t plane,
  input  wire logic            q_full,
  output spi_pkg::qpush_t      qpush
);
  import spi_pkg::*;

  logic                 advance;
  logic                 f1_v_r;
  logic signed [PW-1:0] pa_r [3];
  logic signed [PW-1:0] pb_r [3];
  logic signed [OW-1:0] off_r;
  vec_t                 a_r;
  vec_t                 b_r;
  logic                 f2_v_r;
  qent_t                f2_r;

  logic signed [DW-1:0] s0;
  logic signed [DW-1:0] s1;
  logic signed [EW-1:0] diff;
  qent_t                f2_nxt;

  // hold both stages while the classified request cannot enter the queue
  assign advance      = !f2_v_r || !q_full;
  assign in_seg.ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (advance) begin
      f1_v_r <= in_seg.valid;
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pa_r[0] <= plane.nx * in_seg.data.start_x;
      pa_r[1] <= plane.ny * in_seg.data.start_y;
      pa_r[2] <= plane.nz * in_seg.data.start_z;
      pb_r[0] <= plane.nx * in_seg.data.end_x;
      pb_r[1] <= plane.ny * in_seg.data.end_y;
      pb_r[2] <= plane.nz * in_seg.data.end_z;
      off_r   <= plane.off;
      a_r     <= '{x: in_seg.data.start_x, y: in_seg.data.start_y, z: in_seg.data.start_z};
      b_r     <= '{x: in_seg.data.end_x, y: in_seg.data.end_y, z: in_seg.data.end_z};
      f2_r    <= f2_nxt;
    end
  end

  always_comb begin
    s0   = DW'(pa_r[0]) + DW'(pa_r[1]) + DW'(pa_r[2]) + (DW'(off_r) <<< OSH);
    s1   = DW'(pb_r[0]) + DW'(pb_r[1]) + DW'(pb_r[2]) + (DW'(off_r) <<< OSH);
    diff = EW'(s0) - EW'(s1);
    f2_nxt.num  = (s0 < 0) ? NW'(-s0) : NW'(s0);
    f2_nxt.den  = (diff < 0) ? EW'(-diff) : EW'(diff);
    f2_nxt.far  = b_r;
    f2_nxt.base = a_r;
    if ((s0 > 0 && s1 > 0) || (s0 < 0 && s1 < 0)) begin
      f2_nxt.kind = KIND_NONE;
      f2_nxt.base = '0;
    end else if (s0 == 0) begin
      f2_nxt.kind = (s1 == 0) ? KIND_ON_PLANE : KIND_TOUCH;
    end else if (s1 == 0) begin
      f2_nxt.kind = KIND_TOUCH;
      f2_nxt.base = b_r;
    end else begin
      f2_nxt.kind = KIND_CROSS;
    end
  end

  assign qpush.push = f2_v_r && !q_full;
  assign qpush.data = f2_r;

endmodule
`default_nettype wire

// ----- design/spi_queue.sv -----
// Short request queue between the classifier and the divider pipeline.
`default_nettype none
module spi_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire spi_pkg::qpush_t qpush,
  input  wire logic            pop,
  output spi_pkg::qstat_t      qstat
);
  import spi_pkg::*;

  qent_t           mem_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r;
  logic [QAW-1:0]  rd_ptr_r;
  logic [QCW-1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (qpush.push) mem_r[wr_ptr_r] <= qpush.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (qpush.push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + QCW'(qpush.push) - QCW'(pop);
    end
  end

  assign qstat.full  = (cnt_r == QCW'(QDEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign qstat.head  = mem_r[rd_ptr_r];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(qpush.push && qstat.full)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && qstat.empty)) else $error("queue pop while empty");

endmodule
`default_nettype wire

// ----- design/spi_back.sv -----
// Back end: pipelined fraction divider, interpolation and result register.
`default_nettype none
module spi_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire spi_pkg::qstat_t qstat,
  output logic                 pop,
  spi_out_if.source            out_hit
);
  import spi_pkg::*;

  logic          advance;

  logic          dv_r   [NSTEP];
  logic [RW-1:0] dr_r   [NSTEP];
  logic [FW-1:0] dq_r   [NSTEP];
  logic [EW-1:0] dden_r [NSTEP];
  kind_t         dk_r   [NSTEP];
  vec_t          db_r   [NSTEP];
  vec_t          df_r   [NSTEP];

  logic [RW-1:0] rin   [NSTEP];
  logic [FW-1:0] qin   [NSTEP];
  logic [EW-1:0] denin [NSTEP];
  logic [RW-1:0] rsh   [NSTEP];
  logic          qbit  [NSTEP];
  logic [RW-1:0] rout  [NSTEP];

  logic          ml_v_r;
  kind_t         ml_k_r;
  vec_t          ml_b_r;
  logic [CW:0]   off_r [3];
  logic          neg_r [3];

  logic          out_v_r;
  hit_t          out_r;
  hit_t          out_nxt;

  function automatic logic [CW:0] off_mag(input logic signed [CW-1:0] a,
                                          input logic signed [CW-1:0] b,
                                          input logic [FW-1:0] t);
    logic signed [CW:0] d;
    logic [CW:0]        m;
    logic [CW+FW:0]     p;
    d = (CW+1)'(b) - (CW+1)'(a);
    m = (d < 0) ? (CW+1)'(-d) : (CW+1)'(d);
    p = m * (CW+FW+1)'(t);
    return p[CW+FW:FW];
  endfunction

  // the whole back end moves together whenever the result slot frees up
  assign advance = !out_v_r || out_hit.ready;
  assign pop     = advance && !qstat.empty;

  always_comb begin
    for (int k = 0; k < NSTEP; k++) begin
      if (k == 0) begin
        rin[k]   = RW'(qstat.head.num);
        qin[k]   = '0;
        denin[k] = qstat.head.den;
      end else begin
        rin[k]   = dr_r[k-1];
        qin[k]   = dq_r[k-1];
        denin[k] = dden_r[k-1];
      end
      rsh[k] = rin[k] << 1;
      qbit[k] = (rsh[k] >= RW'(denin[k]));
      rout[k] = qbit[k] ? (rsh[k] - RW'(denin[k])) : rsh[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTEP; k++) dv_r[k] <= 1'b0;
      ml_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (advance) begin
      dv_r[0] <= !qstat.empty;
      for (int k = 1; k < NSTEP; k++) dv_r[k] <= dv_r[k-1];
      ml_v_r  <= dv_r[NSTEP-1];
      out_v_r <= ml_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < NSTEP; k++) begin
        dr_r[k]   <= rout[k];
        dq_r[k]   <= {qin[k][FW-2:0], qbit[k]};
        dden_r[k] <= denin[k];
      end
      dk_r[0] <= qstat.head.kind;
      db_r[0] <= qstat.head.base;
      df_r[0] <= qstat.head.far;
      for (int k = 1; k < NSTEP; k++) begin
        dk_r[k] <= dk_r[k-1];
        db_r[k] <= db_r[k-1];
        df_r[k] <= df_r[k-1];
      end
      ml_k_r   <= dk_r[NSTEP-1];
      ml_b_r   <= db_r[NSTEP-1];
      off_r[0] <= off_mag(db_r[NSTEP-1].x, df_r[NSTEP-1].x, dq_r[NSTEP-1]);
      off_r[1] <= off_mag(db_r[NSTEP-1].y, df_r[NSTEP-1].y, dq_r[NSTEP-1]);
      off_r[2] <= off_mag(db_r[NSTEP-1].z, df_r[NSTEP-1].z, dq_r[NSTEP-1]);
      neg_r[0] <= (df_r[NSTEP-1].x < db_r[NSTEP-1].x);
      neg_r[1] <= (df_r[NSTEP-1].y < db_r[NSTEP-1].y);
      neg_r[2] <= (df_r[NSTEP-1].z < db_r[NSTEP-1].z);
      out_r    <= out_nxt;
    end
  end

  always_comb begin
    out_nxt.cross_kind = ml_k_r;
    if (ml_k_r == KIND_CROSS) begin
      out_nxt.hit_x = neg_r[0] ? CW'((CW+1)'(ml_b_r.x) - off_r[0])
                               : CW'((CW+1)'(ml_b_r.x) + off_r[0]);
      out_nxt.hit_y = neg_r[1] ? CW'((CW+1)'(ml_b_r.y) - off_r[1])
                               : CW'((CW+1)'(ml_b_r.y) + off_r[1]);
      out_nxt.hit_z = neg_r[2] ? CW'((CW+1)'(ml_b_r.z) - off_r[2])
                               : CW'((CW+1)'(ml_b_r.z) + off_r[2]);
    end else begin
      out_nxt.hit_x = ml_b_r.x;
      out_nxt.hit_y = ml_b_r.y;
      out_nxt.hit_z = ml_b_r.z;
    end
  end

  assign out_hit.valid = out_v_r;
  assign out_hit.data  = out_r;

endmodule
`default_nettype wire

// ----- design/segment_plane_intersect.sv -----
// Top level: segment/plane intersection with APB plane registers.
// Pipeline: product stage, classify stage, queue, 16 divider stages, multiply,
//   result reg.
// Throughput: one request per cycle while out_hit is ready; the pipelined restoring divider
//   takes one quotient bit per stage, so it accepts a new fraction every unstalled cycle.
// Reset: synchronous active-low rst_n empties the pipeline and queue and
//   loads the plane registers with normal (0, 0, 1.0) and offset 0.
`default_nettype none
module segment_plane_intersect (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  spi_in_if.sink                    in_seg,
  spi_out_if.source                 out_hit,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [spi_pkg::AW-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import spi_pkg::*;

  plane_t plane_r;
  logic   cfg_wr;
  qpush_t qpush;
  qstat_t qstat;
  logic   pop;

  // Plane registers: written in the APB access phase, word addressed.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r.nx  <= '0;
      plane_r.ny  <= '0;
      plane_r.nz  <= NZ_RESET;
      plane_r.off <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_NX:  plane_r.nx  <= pwdata[CW-1:0];
        REG_NY:  plane_r.ny  <= pwdata[CW-1:0];
        REG_NZ:  plane_r.nz  <= pwdata[CW-1:0];
        REG_OFF: plane_r.off <= pwdata[OW-1:0];
        default: ;
      endcase
    end
  end

  // Read back the raw register bits, zero-extended.
  always_comb begin
    case (paddr[3:2])
      REG_NX:  prdata = 32'(unsigned'(plane_r.nx));
      REG_NY:  prdata = 32'(unsigned'(plane_r.ny));
      REG_NZ:  prdata = 32'(unsigned'(plane_r.nz));
      REG_OFF: prdata = 32'(unsigned'(plane_r.off));
      default: prdata = '0;
    endcase
  end

  // Front: compute both plane distances, classify, push into the queue.
  spi_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_seg (in_seg),
    .plane  (plane_r),
    .q_full (qstat.full),
    .qpush  (qpush)
  );

  // Queue: decouple the front from back-end stalls.
  spi_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .qpush (qpush),
    .pop   (pop),
    .qstat (qstat)
  );

  // Back: divide |s0| by |s0-s1| to a Q0.16 fraction, interpolate, hold result.
  spi_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .qstat   (qstat),
    .pop     (pop),
    .out_hit (out_hit)
  );

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_hit.valid && out_hit.data.cross_kind == KIND_NONE) |->
      (out_hit.data.hit_x == '0 && out_hit.data.hit_y == '0 && out_hit.data.hit_z == '0))
    else $error("no-crossing result with nonzero hit point");
  a_plane_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!cfg_wr) |=> $stable(plane_r)) else $error("plane changed without a write");

endmodule
`default_nettype wire
